### rtl/core/ttm_pkg.sv
// Shared types and constants of the telemetry threshold monitor.
`timescale 1ns / 1ps

package ttm_pkg;

    localparam int MAX_RECORDS = 65536;
    localparam int REC_W       = 17;
    localparam int ANOM_W      = 19;
    localparam logic [ANOM_W-1:0] ANOM_MAX = {ANOM_W{1'b1}};

    localparam int IN_W   = 104;
    localparam int OUT_W  = 200;
    localparam int CFG_W  = 24;
    localparam int CFGI_W = 3;

    localparam int DIV_W     = 48;
    localparam int DIV_CNT_W = $clog2(DIV_W);

    localparam logic [CFGI_W-1:0] REG_BATTERY_LOW  = 3'd0;
    localparam logic [CFGI_W-1:0] REG_SPEED_HIGH   = 3'd1;
    localparam logic [CFGI_W-1:0] REG_TEMP_HIGH    = 3'd2;
    localparam logic [CFGI_W-1:0] REG_SAT_MIN      = 3'd3;
    localparam logic [CFGI_W-1:0] REG_ALT_JUMP     = 3'd4;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV_SPD,
        S_DIV_ALT
    } ttm_state_t;

    typedef struct packed {
        logic [5:0]         satellites;
        logic signed [15:0] temperature;
        logic [13:0]        battery;
        logic signed [23:0] altitude;
        logic signed [15:0] speed;
        logic [23:0]        time_stamp;
    } ttm_record_t;

    typedef struct packed {
        logic [13:0]        battery_low;
        logic signed [15:0] speed_high;
        logic signed [15:0] temp_high;
        logic [5:0]         sat_min;
        logic [23:0]        alt_jump;
    } ttm_limits_t;

    typedef struct packed {
        logic [4:0]  mask;
        logic [23:0] change;
        logic [2:0]  hits;
    } ttm_check_t;

    typedef struct packed {
        logic                    start;
        logic signed [DIV_W-1:0] dividend;
        logic [REC_W-1:0]        divisor;
    } ttm_div_req_t;

    typedef struct packed {
        logic                    done;
        logic signed [DIV_W-1:0] quotient;
    } ttm_div_rsp_t;

endpackage

### rtl/core/ttm_check.sv
// Threshold comparisons and altitude jump of one telemetry record.
`timescale 1ns / 1ps

module ttm_check import ttm_pkg::*; (
    input  ttm_record_t        rec,
    input  ttm_limits_t        limits,
    input  logic signed [23:0] prev_altitude,
    input  logic               run_started,
    output ttm_check_t         result
);

    logic signed [24:0] diff;
    logic [24:0]        diff_abs;
    logic [23:0]        change;
    logic [4:0]         mask;

    always_comb begin
        diff     = 25'(rec.altitude) - 25'(prev_altitude);
        diff_abs = diff[24] ? 25'(-diff) : 25'(diff);
        change   = run_started ? diff_abs[23:0] : 24'd0;
        mask[0]  = rec.battery < limits.battery_low;
        mask[1]  = rec.speed > limits.speed_high;
        mask[2]  = rec.temperature > limits.temp_high;
        mask[3]  = rec.satellites < limits.sat_min;
        mask[4]  = run_started && (change > limits.alt_jump);
        result.mask   = mask;
        result.change = change;
        result.hits   = 3'(mask[0]) + 3'(mask[1]) + 3'(mask[2]) + 3'(mask[3]) + 3'(mask[4]);
    end

endmodule

### rtl/core/ttm_divider.sv
// Shared restoring divider for the run averages, one quotient bit per cycle.
`timescale 1ns / 1ps

module ttm_divider import ttm_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  ttm_div_req_t req,
    output ttm_div_rsp_t rsp
);

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 neg_reg;
    logic [DIV_W-1:0]     quo_reg;
    logic [REC_W-1:0]     rem_reg;
    logic [REC_W-1:0]     dsor_reg;

    logic [REC_W:0]   shifted;
    logic [REC_W+1:0] trial;
    logic [DIV_W-1:0] magnitude;

    always_comb begin
        shifted   = {rem_reg, quo_reg[DIV_W-1]};
        trial     = {1'b0, shifted} - {2'b00, dsor_reg};
        magnitude = req.dividend[DIV_W-1] ? DIV_W'(-req.dividend) : DIV_W'(req.dividend);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIV_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            neg_reg  <= req.dividend[DIV_W-1];
            quo_reg  <= magnitude;
            rem_reg  <= '0;
            dsor_reg <= req.divisor;
        end else if (busy_reg) begin
            if (!trial[REC_W+1]) begin
                rem_reg <= trial[REC_W-1:0];
                quo_reg <= {quo_reg[DIV_W-2:0], 1'b1};
            end else begin
                rem_reg <= shifted[REC_W-1:0];
                quo_reg <= {quo_reg[DIV_W-2:0], 1'b0};
            end
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = neg_reg ? DIV_W'(-$signed(quo_reg)) : $signed(quo_reg);

endmodule

### rtl/core/telemetry_threshold_monitor_core.sv
// Top level of the telemetry threshold monitor: run state, sequencer and output register.
`timescale 1ns / 1ps

// A record that does not end a run is accepted and its result is registered on the
// next edge, so such records can follow every cycle while the result side keeps up;
// s_tready is low while an unaccepted result waits. A record that ends a run
// (tlast, or the record that reaches the record limit) also needs the two run
// averages, which the single shared restoring divider produces one after the other
// at one quotient bit per cycle, each handed over through a registered done flag;
// its result appears once the second quotient is done, and no record is taken
// meanwhile. m_tuser carries the summary flag; the summary fields of m_tdata are
// zero on records that do not end a run.

module telemetry_threshold_monitor_core import ttm_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_we,
    input  logic [CFGI_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]  cfg_data,
    input  logic              s_tvalid,
    output logic              s_tready,
    // time_stamp[23:0], speed[39:24], altitude[63:40], battery[77:64],
    // temperature[93:78], satellites[99:94], zero fill[103:100]
    input  logic [IN_W-1:0]   s_tdata,
    input  logic              s_tlast,
    output logic              m_tvalid,
    input  logic              m_tready,
    // stamp_out[23:0], anomaly_mask[28:24], altitude_change[52:29],
    // anomaly_total[71:53], record_total[88:72], peak_speed[104:89],
    // mean_speed[120:105], peak_altitude[144:121], mean_altitude[168:145],
    // lowest_charge[182:169], peak_temperature[198:183], zero fill[199]
    output logic [OUT_W-1:0]  m_tdata,
    // summary_valid[0]
    output logic              m_tuser
);

    ttm_state_t  state_reg, state_next;
    ttm_limits_t limits_reg;

    logic                    run_started_reg;
    logic signed [23:0]      prev_alt_reg;
    logic signed [15:0]      high_speed_reg;
    logic signed [39:0]      speed_sum_reg;
    logic signed [23:0]      high_alt_reg;
    logic signed [47:0]      alt_sum_reg;
    logic [13:0]             low_batt_reg;
    logic signed [15:0]      high_temp_reg;
    logic [REC_W-1:0]        records_reg;
    logic [ANOM_W-1:0]       anom_reg;
    logic signed [DIV_W-1:0] alt_sum_hold_reg;

    logic                    out_valid_reg;
    logic                    out_summary_reg;
    logic [23:0]             out_stamp_reg;
    logic [4:0]              out_mask_reg;
    logic [23:0]             out_change_reg;
    logic [ANOM_W-1:0]       out_anom_reg;
    logic [REC_W-1:0]        out_records_reg;
    logic [15:0]             out_pk_speed_reg;
    logic [15:0]             out_mn_speed_reg;
    logic [23:0]             out_pk_alt_reg;
    logic [23:0]             out_mn_alt_reg;
    logic [13:0]             out_lo_batt_reg;
    logic [15:0]             out_pk_temp_reg;

    ttm_record_t  rec;
    ttm_check_t   chk;
    ttm_div_req_t div_req;
    ttm_div_rsp_t div_rsp;

    logic                    accept;
    logic                    is_last;
    logic signed [15:0]      high_speed_new;
    logic signed [23:0]      high_alt_new;
    logic [13:0]             low_batt_new;
    logic signed [15:0]      high_temp_new;
    logic signed [39:0]      speed_sum_new;
    logic signed [47:0]      alt_sum_new;
    logic [REC_W-1:0]        records_new;
    logic [ANOM_W:0]         anom_sum;
    logic [ANOM_W-1:0]       anom_new;

    assign rec = ttm_record_t'(s_tdata[99:0]);

    ttm_check u_check (
        .rec           (rec),
        .limits        (limits_reg),
        .prev_altitude (prev_alt_reg),
        .run_started   (run_started_reg),
        .result        (chk)
    );

    ttm_divider u_divider (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    assign s_tready = (state_reg == S_IDLE) && (!out_valid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        if (run_started_reg) begin
            high_speed_new = (rec.speed > high_speed_reg) ? rec.speed : high_speed_reg;
            high_alt_new   = (rec.altitude > high_alt_reg) ? rec.altitude : high_alt_reg;
            low_batt_new   = (rec.battery < low_batt_reg) ? rec.battery : low_batt_reg;
            high_temp_new  = (rec.temperature > high_temp_reg) ? rec.temperature
                                                               : high_temp_reg;
        end else begin
            high_speed_new = rec.speed;
            high_alt_new   = rec.altitude;
            low_batt_new   = rec.battery;
            high_temp_new  = rec.temperature;
        end
        speed_sum_new = speed_sum_reg + 40'(rec.speed);
        alt_sum_new   = alt_sum_reg + 48'(rec.altitude);
        records_new   = records_reg + 1'b1;
        anom_sum      = {1'b0, anom_reg} + (ANOM_W + 1)'(chk.hits);
        anom_new      = (anom_sum > (ANOM_W + 1)'(ANOM_MAX)) ? ANOM_MAX : anom_sum[ANOM_W-1:0];
        is_last       = s_tlast || (records_new >= REC_W'(MAX_RECORDS));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next       = state_reg;
        div_req.start    = 1'b0;
        div_req.dividend = DIV_W'(speed_sum_new);
        div_req.divisor  = records_new;
        unique case (state_reg)
            S_IDLE: begin
                if (accept && is_last) begin
                    div_req.start = 1'b1;
                    state_next    = S_DIV_SPD;
                end
            end
            S_DIV_SPD: begin
                div_req.dividend = alt_sum_hold_reg;
                div_req.divisor  = out_records_reg;
                if (div_rsp.done) begin
                    div_req.start = 1'b1;
                    state_next    = S_DIV_ALT;
                end
            end
            S_DIV_ALT: begin
                div_req.divisor = out_records_reg;
                if (div_rsp.done) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limits_reg.battery_low <= 14'd2000;
            limits_reg.speed_high  <= 16'sd3500;
            limits_reg.temp_high   <= 16'sd5000;
            limits_reg.sat_min     <= 6'd6;
            limits_reg.alt_jump    <= 24'd3000;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_BATTERY_LOW: limits_reg.battery_low <= cfg_data[13:0];
                REG_SPEED_HIGH:  limits_reg.speed_high  <= cfg_data[15:0];
                REG_TEMP_HIGH:   limits_reg.temp_high   <= cfg_data[15:0];
                REG_SAT_MIN:     limits_reg.sat_min     <= cfg_data[5:0];
                REG_ALT_JUMP:    limits_reg.alt_jump    <= cfg_data[23:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_started_reg <= 1'b0;
            prev_alt_reg    <= '0;
            high_speed_reg  <= '0;
            speed_sum_reg   <= '0;
            high_alt_reg    <= '0;
            alt_sum_reg     <= '0;
            low_batt_reg    <= '0;
            high_temp_reg   <= '0;
            records_reg     <= '0;
            anom_reg        <= '0;
        end else if (accept) begin
            if (is_last) begin
                run_started_reg <= 1'b0;
                prev_alt_reg    <= '0;
                high_speed_reg  <= '0;
                speed_sum_reg   <= '0;
                high_alt_reg    <= '0;
                alt_sum_reg     <= '0;
                low_batt_reg    <= '0;
                high_temp_reg   <= '0;
                records_reg     <= '0;
                anom_reg        <= '0;
            end else begin
                run_started_reg <= 1'b1;
                prev_alt_reg    <= rec.altitude;
                high_speed_reg  <= high_speed_new;
                speed_sum_reg   <= speed_sum_new;
                high_alt_reg    <= high_alt_new;
                alt_sum_reg     <= alt_sum_new;
                low_batt_reg    <= low_batt_new;
                high_temp_reg   <= high_temp_new;
                records_reg     <= records_new;
                anom_reg        <= anom_new;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (accept) begin
            out_valid_reg <= !is_last;
        end else if (state_reg == S_DIV_ALT && div_rsp.done) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            out_summary_reg <= is_last;
            out_stamp_reg   <= rec.time_stamp;
            out_mask_reg    <= chk.mask;
            out_change_reg  <= chk.change;
            out_anom_reg    <= anom_new;
            alt_sum_hold_reg <= alt_sum_new;
            if (is_last) begin
                out_records_reg  <= records_new;
                out_pk_speed_reg <= high_speed_new;
                out_pk_alt_reg   <= high_alt_new;
                out_lo_batt_reg  <= low_batt_new;
                out_pk_temp_reg  <= high_temp_new;
            end else begin
                out_records_reg  <= '0;
                out_pk_speed_reg <= '0;
                out_pk_alt_reg   <= '0;
                out_lo_batt_reg  <= '0;
                out_pk_temp_reg  <= '0;
            end
            out_mn_speed_reg <= '0;
            out_mn_alt_reg   <= '0;
        end else if (state_reg == S_DIV_SPD && div_rsp.done) begin
            out_mn_speed_reg <= div_rsp.quotient[15:0];
        end else if (state_reg == S_DIV_ALT && div_rsp.done) begin
            out_mn_alt_reg <= div_rsp.quotient[23:0];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_summary_reg;
    assign m_tdata  = {1'b0, out_pk_temp_reg, out_lo_batt_reg, out_mn_alt_reg, out_pk_alt_reg,
                       out_mn_speed_reg, out_pk_speed_reg, out_records_reg, out_anom_reg,
                       out_change_reg, out_mask_reg, out_stamp_reg};

endmodule

### rtl/core/ttm_checker.sv
// Port-level assertions of the telemetry threshold monitor and their bind.
`timescale 1ns / 1ps

module ttm_checker import ttm_pkg::*; (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_tready,
    input logic              m_tvalid,
    input logic              m_tready,
    input logic [OUT_W-1:0]  m_tdata,
    input logic              m_tuser
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("Result transaction changed while stalled.");

    a_no_take_while_blocked: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid && !m_tready))
        else $error("Input ready while a result waits.");

    a_summary_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata[198:72] == '0)
        else $error("Summary fields are not zero on a record inside a run.");

    a_summary_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata[88:72] != '0)
        else $error("Summary shows an empty run.");

    a_total_covers_mask: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[71:53] >= ANOM_W'($countones(m_tdata[28:24])))
        else $error("Anomaly total is below the anomalies of this record.");

endmodule

bind telemetry_threshold_monitor_core ttm_checker u_ttm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

### dv/telemetry_threshold_monitor_core_tb.sv
// Self-checking testbench of the telemetry threshold monitor core with a built-in predictor.
`timescale 1ns / 1ps

module telemetry_threshold_monitor_core_tb;
    import ttm_pkg::*;

    localparam logic [CFGI_W-1:0] REG_UNUSED = 3'd7;

    typedef struct packed {
        logic               pad;
        logic signed [15:0] peak_temp;
        logic [13:0]        low_charge;
        logic signed [23:0] mean_alt;
        logic signed [23:0] peak_alt;
        logic signed [15:0] mean_speed;
        logic signed [15:0] peak_speed;
        logic [16:0]        rec_total;
        logic [18:0]        anom_total;
        logic [23:0]        alt_change;
        logic [4:0]         mask;
        logic [23:0]        stamp;
    } verdict_t;

    typedef struct packed {
        logic     summary;
        verdict_t body;
    } verdict_entry_t;

    typedef struct packed {
        logic              is_cfg;
        logic [CFGI_W-1:0] reg_idx;
        logic [CFG_W-1:0]  reg_val;
        ttm_record_t       rec;
        logic              last;
        logic              typed;
        verdict_entry_t    want;
    } stim_row_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              cfg_we = 1'b0;
    logic [CFGI_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]  cfg_data = '0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [IN_W-1:0]   s_tdata = '0;
    logic              s_tlast = 1'b0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [OUT_W-1:0]  m_tdata;
    logic              m_tuser;

    telemetry_threshold_monitor_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #5 aclk = ~aclk;

    ttm_limits_t        limits;
    logic               run_open;
    logic signed [23:0] prev_alt;
    logic signed [15:0] top_speed;
    logic signed [23:0] top_alt;
    logic [13:0]        min_charge;
    logic signed [15:0] top_temp;
    longint             speed_acc;
    longint             alt_acc;
    int                 rec_count;
    int                 anom_count;

    verdict_entry_t pending_verdicts[$];
    int             mismatches = 0;
    int             send_idle_pct = 7;
    int             recv_idle_pct = 51;

    function automatic void clear_run();
        run_open   = 1'b0;
        prev_alt   = '0;
        top_speed  = '0;
        top_alt    = '0;
        min_charge = '0;
        top_temp   = '0;
        speed_acc  = 0;
        alt_acc    = 0;
        rec_count  = 0;
        anom_count = 0;
    endfunction

    function automatic verdict_entry_t score_record(ttm_record_t r, logic last);
        verdict_entry_t e;
        longint         step;
        logic [23:0]    change;
        logic [4:0]     mask;
        mask = '0;
        change = '0;
        if (r.battery < limits.battery_low) mask[0] = 1'b1;
        if (r.speed > limits.speed_high) mask[1] = 1'b1;
        if (r.temperature > limits.temp_high) mask[2] = 1'b1;
        if (r.satellites < limits.sat_min) mask[3] = 1'b1;
        if (run_open) begin
            step = longint'(r.altitude) - longint'(prev_alt);
            if (step < 0) step = -step;
            if (step > 64'sh00FF_FFFF) step = 64'sh00FF_FFFF;
            change = step[23:0];
            if (change > limits.alt_jump) mask[4] = 1'b1;
            if (r.speed > top_speed) top_speed = r.speed;
            if (r.altitude > top_alt) top_alt = r.altitude;
            if (r.battery < min_charge) min_charge = r.battery;
            if (r.temperature > top_temp) top_temp = r.temperature;
        end else begin
            top_speed  = r.speed;
            top_alt    = r.altitude;
            min_charge = r.battery;
            top_temp   = r.temperature;
        end
        run_open  = 1'b1;
        prev_alt  = r.altitude;
        speed_acc = speed_acc + longint'(r.speed);
        alt_acc   = alt_acc + longint'(r.altitude);
        rec_count = rec_count + 1;
        anom_count = anom_count + $countones(mask);
        if (anom_count > int'(ANOM_MAX)) anom_count = int'(ANOM_MAX);
        if (rec_count >= MAX_RECORDS) last = 1'b1;

        e = '0;
        e.body.stamp      = r.time_stamp;
        e.body.mask       = mask;
        e.body.alt_change = change;
        e.body.anom_total = 19'(anom_count);
        if (last) begin
            e.summary         = 1'b1;
            e.body.rec_total  = 17'(rec_count);
            e.body.peak_speed = top_speed;
            e.body.mean_speed = 16'(speed_acc / longint'(rec_count));
            e.body.peak_alt   = top_alt;
            e.body.mean_alt   = 24'(alt_acc / longint'(rec_count));
            e.body.low_charge = min_charge;
            e.body.peak_temp  = top_temp;
            clear_run();
        end
        return e;
    endfunction

    function automatic stim_row_t rec_row(int stamp, int spd, int alt, int bat, int tmp,
                                          int sat, logic last, logic typed,
                                          logic [4:0] mask);
        stim_row_t row;
        row = '0;
        row.rec.time_stamp  = 24'(stamp);
        row.rec.speed       = 16'(spd);
        row.rec.altitude    = 24'(alt);
        row.rec.battery     = 14'(bat);
        row.rec.temperature = 16'(tmp);
        row.rec.satellites  = 6'(sat);
        row.last  = last;
        row.typed = typed;
        if (typed) begin
            row.want.summary         = 1'b1;
            row.want.body.stamp      = row.rec.time_stamp;
            row.want.body.mask       = mask;
            row.want.body.anom_total = 19'($countones(mask));
            row.want.body.rec_total  = 17'd1;
            row.want.body.peak_speed = row.rec.speed;
            row.want.body.mean_speed = row.rec.speed;
            row.want.body.peak_alt   = row.rec.altitude;
            row.want.body.mean_alt   = row.rec.altitude;
            row.want.body.low_charge = row.rec.battery;
            row.want.body.peak_temp  = row.rec.temperature;
        end
        return row;
    endfunction

    function automatic stim_row_t cfg_row(logic [CFGI_W-1:0] idx, logic [CFG_W-1:0] val);
        stim_row_t row;
        row = '0;
        row.is_cfg  = 1'b1;
        row.reg_idx = idx;
        row.reg_val = val;
        return row;
    endfunction

    function automatic int near(int centre, int lo, int hi);
        int v;
        v = centre + int'($urandom_range(6)) - 3;
        if (v < lo) v = lo;
        if (v > hi) v = hi;
        return v;
    endfunction

    function automatic int pick_limit(int lo, int hi, int span);
        case ($urandom_range(3))
            0: return lo;
            1: return hi;
            default: return lo + int'($urandom_range(span));
        endcase
    endfunction

    function automatic ttm_limits_t random_limits();
        ttm_limits_t l;
        l.battery_low = 14'(pick_limit(0, 10000, 10000));
        l.speed_high  = 16'(pick_limit(-32768, 32767, 65535));
        l.temp_high   = 16'(pick_limit(-32768, 32767, 65535));
        l.sat_min     = 6'(pick_limit(0, 63, 63));
        l.alt_jump    = 24'(pick_limit(0, 16777215, 20000));
        return l;
    endfunction

    function automatic ttm_record_t random_record();
        ttm_record_t r;
        int          delta;
        r.time_stamp = 24'($urandom);
        if ($urandom_range(2) == 0) r.speed = 16'(near(int'(limits.speed_high), -32768, 32767));
        else r.speed = 16'($urandom);
        if ($urandom_range(2) == 0) begin
            r.temperature = 16'(near(int'(limits.temp_high), -32768, 32767));
        end else begin
            r.temperature = 16'($urandom);
        end
        case ($urandom_range(15))
            0: r.battery = 14'($urandom_range(16383, 10001));
            1, 2, 3, 4, 5: r.battery = 14'(near(int'(limits.battery_low), 0, 10000));
            default: r.battery = 14'($urandom_range(10000));
        endcase
        if ($urandom_range(2) == 0) r.satellites = 6'(near(int'(limits.sat_min), 0, 63));
        else r.satellites = 6'($urandom);
        if ($urandom_range(2) == 0) begin
            r.altitude = 24'($urandom);
        end else begin
            delta = near(int'(limits.alt_jump), 0, 16777215);
            if ($urandom_range(1) == 0) delta = -delta;
            r.altitude = 24'(longint'(prev_alt) + longint'(delta));
        end
        return r;
    endfunction

    task automatic compare_field(string name, logic [47:0] want, logic [47:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("mismatch in %s: expected %0h, got %0h", name, want, got);
            end
        end
    endtask

    task automatic check_result();
        verdict_entry_t want;
        verdict_t       got;
        got = verdict_t'(m_tdata);
        if (pending_verdicts.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("result with no record pending: %h", m_tdata);
        end else begin
            want = pending_verdicts.pop_front();
            compare_field("summary_valid", want.summary, m_tuser);
            compare_field("stamp_out", want.body.stamp, got.stamp);
            compare_field("anomaly_mask", want.body.mask, got.mask);
            compare_field("altitude_change", want.body.alt_change, got.alt_change);
            compare_field("anomaly_total", want.body.anom_total, got.anom_total);
            compare_field("record_total", want.body.rec_total, got.rec_total);
            compare_field("peak_speed", want.body.peak_speed, got.peak_speed);
            compare_field("mean_speed", want.body.mean_speed, got.mean_speed);
            compare_field("peak_altitude", want.body.peak_alt, got.peak_alt);
            compare_field("mean_altitude", want.body.mean_alt, got.mean_alt);
            compare_field("lowest_charge", want.body.low_charge, got.low_charge);
            compare_field("peak_temperature", want.body.peak_temp, got.peak_temp);
            compare_field("zero fill", want.body.pad, got.pad);
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) check_result();
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic send_record(ttm_record_t r, logic last, logic typed,
                               verdict_entry_t typed_entry);
        verdict_entry_t predicted;
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tdata  <= {4'b0, r.satellites, r.temperature, r.battery, r.altitude, r.speed,
                     r.time_stamp};
        s_tlast  <= last;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predicted = score_record(r, last);
        pending_verdicts.push_back(typed ? typed_entry : predicted);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_verdicts.size() != 0) @(posedge aclk);
    endtask

    task automatic write_register(logic [CFGI_W-1:0] idx, logic [CFG_W-1:0] data);
        case (idx)
            REG_BATTERY_LOW: limits.battery_low = data[13:0];
            REG_SPEED_HIGH:  limits.speed_high  = data[15:0];
            REG_TEMP_HIGH:   limits.temp_high   = data[15:0];
            REG_SAT_MIN:     limits.sat_min     = data[5:0];
            REG_ALT_JUMP:    limits.alt_jump    = data[23:0];
            default: ;
        endcase
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_we    <= 1'b1;
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic program_limits(ttm_limits_t l);
        write_register(REG_BATTERY_LOW, {10'($urandom), l.battery_low});
        write_register(REG_SPEED_HIGH, {8'($urandom), l.speed_high});
        write_register(REG_TEMP_HIGH, {8'($urandom), l.temp_high});
        write_register(REG_SAT_MIN, {18'($urandom), l.sat_min});
        write_register(REG_ALT_JUMP, l.alt_jump);
    endtask

    initial begin : main_sequence
        stim_row_t      directed[$];
        verdict_entry_t none;
        int             sent;
        int             run_len;

        none = '0;
        limits.battery_low = 14'd2000;
        limits.speed_high  = 16'sd3500;
        limits.temp_high   = 16'sd5000;
        limits.sat_min     = 6'd6;
        limits.alt_jump    = 24'd3000;
        clear_run();

        directed.push_back(rec_row(0, 0, 0, 10000, 0, 63, 1'b1, 1'b1, 5'h00));
        directed.push_back(rec_row(16777215, 32767, 8388607, 0, 32767, 0, 1'b1, 1'b1, 5'h0F));
        directed.push_back(rec_row(1000, 3500, 12345, 2000, 5000, 6, 1'b1, 1'b1, 5'h00));
        directed.push_back(rec_row(1001, 3501, -12345, 1999, 5001, 5, 1'b1, 1'b1, 5'h0F));
        directed.push_back(rec_row(1002, -32768, -8388608, 10000, -32768, 63, 1'b1, 1'b1,
                                   5'h00));
        directed.push_back(rec_row(1003, 0, 0, 16383, 0, 10, 1'b1, 1'b1, 5'h00));
        directed.push_back(rec_row(2000, 100, -8388608, 5000, 100, 10, 1'b0, 1'b0, 5'h00));
        directed.push_back(rec_row(2001, 200, 8388607, 5000, 100, 10, 1'b0, 1'b0, 5'h00));
        directed.push_back(rec_row(2002, 300, 8385607, 5000, 100, 10, 1'b0, 1'b0, 5'h00));
        directed.push_back(rec_row(2003, -400, 8382606, 5000, 100, 10, 1'b1, 1'b0, 5'h00));
        directed.push_back(cfg_row(REG_BATTERY_LOW, 24'hFFC000));
        directed.push_back(cfg_row(REG_SPEED_HIGH, 24'hFF8000));
        directed.push_back(cfg_row(REG_TEMP_HIGH, 24'h007FFF));
        directed.push_back(cfg_row(REG_SAT_MIN, 24'hFFFFC0));
        directed.push_back(cfg_row(REG_ALT_JUMP, 24'h000000));
        directed.push_back(cfg_row(REG_UNUSED, 24'hFFFFFF));
        directed.push_back(rec_row(3000, -32767, 100, 0, 32767, 0, 1'b0, 1'b0, 5'h00));
        directed.push_back(rec_row(3001, -32768, 100, 0, 0, 0, 1'b0, 1'b0, 5'h00));
        directed.push_back(rec_row(3002, 5, 101, 0, 0, 0, 1'b1, 1'b0, 5'h00));
        directed.push_back(cfg_row(REG_BATTERY_LOW, 24'hFFE710));
        directed.push_back(cfg_row(REG_SPEED_HIGH, 24'h007FFF));
        directed.push_back(cfg_row(REG_TEMP_HIGH, 24'hFF8000));
        directed.push_back(cfg_row(REG_SAT_MIN, 24'h00003F));
        directed.push_back(cfg_row(REG_ALT_JUMP, 24'hFFFFFF));
        directed.push_back(rec_row(4000, 0, -8388608, 9999, -32767, 62, 1'b0, 1'b0, 5'h00));
        directed.push_back(rec_row(4001, 32767, 8388607, 10000, -32768, 63, 1'b1, 1'b0,
                                   5'h00));

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed[i]) begin
            if (directed[i].is_cfg) begin
                wait_drained();
                write_register(directed[i].reg_idx, directed[i].reg_val);
            end else begin
                send_record(directed[i].rec, directed[i].last, directed[i].typed,
                            directed[i].want);
            end
        end

        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 7 : (phase == 1) ? 51 : 0;
            recv_idle_pct = (phase == 0) ? 51 : (phase == 1) ? 7 : 0;
            repeat (4) begin
                wait_drained();
                program_limits(random_limits());
                sent = 0;
                while (sent < 90) begin
                    run_len = $urandom_range(24, 1);
                    for (int k = 0; k < run_len; k++) begin
                        send_record(random_record(), k == run_len - 1, 1'b0, none);
                        sent++;
                    end
                end
            end
        end

        wait_drained();
        repeat (200) @(posedge aclk);
        if (mismatches == 0 && pending_verdicts.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin : watchdog
        #10_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
